// ===== rtl/itrd_pkg.sv =====
// shared types, constants and helpers for the integer to radix digits unit
package itrd_pkg;

  // ascii codes and radix constants
  localparam logic [6:0] CHAR_ZERO       = 7'h30;
  localparam logic [6:0] CHAR_ALPHA_BASE = 7'h37;  // 'A' - 10
  localparam logic [6:0] CHAR_MINUS      = 7'h2d;
  localparam logic [6:0] CHAR_NONE       = 7'h00;
  localparam logic [5:0] DEC_RADIX       = 6'd10;
  localparam logic [5:0] DEC_MAX_DIGIT   = 6'd9;
  localparam logic [5:0] MIN_RADIX       = 6'd2;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // source of the next output item
  typedef enum logic [1:0] {
    SEL_DIGIT,
    SEL_SIGN,
    SEL_ERR
  } out_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     load;   // capture a new input item
    logic     conv;   // shift one magnitude bit into the digit cells
    logic     shift;  // move digit cells up by one position
    logic     emit;   // load the output register
    out_sel_t sel;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic radix_bad;    // incoming radix below two
    logic conv_done;    // last magnitude bit is being shifted in
    logic sign_needed;  // a leading minus is part of the text
    logic top_ok;       // top cell holds a significant digit
    logic pos_last;     // top cell is the least significant digit
    logic out_free;     // output register can take an item this cycle
  } dp_status_t;

  // digit value to ascii
  function automatic logic [6:0] digit_char(input logic [5:0] d);
    logic [6:0] base;
    base = (d > DEC_MAX_DIGIT) ? CHAR_ALPHA_BASE : CHAR_ZERO;
    return base + {1'b0, d};
  endfunction

endpackage

// ===== rtl/integer_to_radix_digits_unit.sv =====
// one item: the magnitude is shifted bit by bit into base-b digit cells, a sign
// state then checks for a leading minus, and the cells then move past the output,
// one character each, leading zero cells skipped; a radix below two gives a single
// error item instead.
// one item in work at a time; the last character waits in the output register
// while the next item is taken. reset clears the state machine and out_valid
module integer_to_radix_digits_unit #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_DIGITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [63:0] in_value,
  input  logic        [5:0]  in_radix,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [6:0]  out_character,
  output logic               out_last,
  output logic               out_error
);
  import itrd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  state_t     state;

  // controller
  itrd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd),
    .state    (state)
  );

  // datapath
  itrd_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .in_radix      (in_radix),
    .cmd           (cmd),
    .status        (status),
    .out_character (out_character),
    .out_last      (out_last),
    .out_error     (out_error),
    .out_valid     (out_valid),
    .out_ready     (out_ready)
  );

  // a new character never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("output item overwritten");

  // an error item is always the only and final one
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> out_last)
    else $error("error item not marked last");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");

  // conversion only runs in its own state
  a_conv_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.conv |-> (state == ST_CONV))
    else $error("conversion step outside conversion");

endmodule

// ===== rtl/itrd_ctrl.sv =====
// controller state machine sequencing conversion and character output
module itrd_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  itrd_pkg::dp_status_t   status,
  output itrd_pkg::dp_cmd_t      cmd,
  output itrd_pkg::state_t       state
);
  import itrd_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '{load: 1'b0, conv: 1'b0, shift: 1'b0, emit: 1'b0, sel: SEL_DIGIT};
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = status.radix_bad ? ST_ERR : ST_CONV;
        end
      end
      ST_ERR: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_ERR;
          state_nxt = ST_IDLE;
        end
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
        if (status.conv_done) begin
          state_nxt = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (!status.sign_needed) begin
          state_nxt = ST_EMIT;
        end else if (status.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_SIGN;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // leading zero cells are skipped without output
        if (!status.top_ok) begin
          cmd.shift = 1'b1;
        end else if (status.out_free) begin
          cmd.emit  = 1'b1;
          cmd.shift = 1'b1;
          if (status.pos_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign state = state_r;

endmodule

// ===== rtl/itrd_dp.sv =====
// datapath: magnitude shifter, base-b digit cells and output register
module itrd_dp #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_DIGITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic signed [63:0]    in_value,
  input  logic        [5:0]     in_radix,
  input  itrd_pkg::dp_cmd_t     cmd,
  output itrd_pkg::dp_status_t  status,
  output logic        [6:0]     out_character,
  output logic                  out_last,
  output logic                  out_error,
  output logic                  out_valid,
  input  logic                  out_ready
);
  import itrd_pkg::*;

  localparam int CW = $clog2(VALUE_BITS);
  localparam int NW = $clog2(MAX_DIGITS + 1);

  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [5:0]            radix_r, radix_nxt;
  logic                  neg_r, neg_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [NW-1:0]         ndig_r, ndig_nxt;
  logic [NW-1:0]         pos_r, pos_nxt;
  logic [5:0]            cell_r   [MAX_DIGITS];
  logic [5:0]            cell_nxt [MAX_DIGITS];
  logic                  out_valid_r, out_valid_nxt;
  logic [6:0]            char_r, char_nxt;
  logic                  last_r, last_nxt;
  logic                  err_r, err_nxt;

  logic [VALUE_BITS-1:0] in_v;
  logic                  in_neg;
  logic [6:0]            dbl   [MAX_DIGITS];
  logic [5:0]            cell_step [MAX_DIGITS];
  logic [MAX_DIGITS-1:0] gen_v, prop_v;
  logic [MAX_DIGITS:0]   sum_v, carry_v;
  logic                  bit_in;
  logic                  out_free;

  // low value bits of the input and their sign
  assign in_v   = in_value[VALUE_BITS-1:0];
  assign in_neg = in_v[VALUE_BITS-1];
  assign bit_in = mag_r[VALUE_BITS-1];

  // per cell doubling with carry lookahead across the row
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      dbl[i]    = {cell_r[i], 1'b0};
      gen_v[i]  = dbl[i] >= {1'b0, radix_r};
      prop_v[i] = (dbl[i] + 7'd1) == {1'b0, radix_r};
    end
    sum_v   = {1'b0, gen_v | prop_v} + {1'b0, gen_v} + {{MAX_DIGITS{1'b0}}, bit_in};
    carry_v = sum_v ^ {1'b0, gen_v | prop_v} ^ {1'b0, gen_v};
    for (int i = 0; i < MAX_DIGITS; i++) begin
      cell_step[i] = 6'(dbl[i] + {6'd0, carry_v[i]}
                        - (carry_v[i+1] ? {1'b0, radix_r} : 7'd0));
    end
  end

  assign out_free = !out_valid_r || out_ready;

  // status to controller
  always_comb begin
    status.radix_bad   = in_radix < MIN_RADIX;
    status.conv_done   = cnt_r == '0;
    status.sign_needed = neg_r && (radix_r == DEC_RADIX) && (ndig_r != NW'(MAX_DIGITS));
    status.top_ok      = pos_r <= ndig_r;
    status.pos_last    = pos_r == NW'(1);
    status.out_free    = out_free;
  end

  // next values of the working registers
  always_comb begin
    mag_nxt   = mag_r;
    radix_nxt = radix_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    ndig_nxt  = ndig_r;
    pos_nxt   = pos_r;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      cell_nxt[i] = cell_r[i];
    end
    if (cmd.load) begin
      mag_nxt   = in_neg ? (~in_v + 1'b1) : in_v;
      radix_nxt = in_radix;
      neg_nxt   = in_neg;
      cnt_nxt   = CW'(VALUE_BITS - 1);
      ndig_nxt  = NW'(1);
      pos_nxt   = NW'(MAX_DIGITS);
      for (int i = 0; i < MAX_DIGITS; i++) begin
        cell_nxt[i] = '0;
      end
    end else if (cmd.conv) begin
      mag_nxt = {mag_r[VALUE_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      // a carry past the highest used cell opens one more digit
      if (carry_v[ndig_r] && (ndig_r != NW'(MAX_DIGITS))) begin
        ndig_nxt = ndig_r + 1'b1;
      end
      for (int i = 0; i < MAX_DIGITS; i++) begin
        cell_nxt[i] = cell_step[i];
      end
    end else if (cmd.shift) begin
      pos_nxt     = pos_r - 1'b1;
      cell_nxt[0] = '0;
      for (int i = 1; i < MAX_DIGITS; i++) begin
        cell_nxt[i] = cell_r[i-1];
      end
    end
  end

  // output register next values
  always_comb begin
    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    err_nxt       = err_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      unique case (cmd.sel)
        SEL_DIGIT: begin
          char_nxt = digit_char(cell_r[MAX_DIGITS-1]);
          last_nxt = pos_r == NW'(1);
          err_nxt  = 1'b0;
        end
        SEL_SIGN: begin
          char_nxt = CHAR_MINUS;
          last_nxt = 1'b0;
          err_nxt  = 1'b0;
        end
        SEL_ERR: begin
          char_nxt = CHAR_NONE;
          last_nxt = 1'b1;
          err_nxt  = 1'b1;
        end
        default: begin
          char_nxt = CHAR_NONE;
          last_nxt = 1'b1;
          err_nxt  = 1'b1;
        end
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    radix_r <= radix_nxt;
    neg_r   <= neg_nxt;
    cnt_r   <= cnt_nxt;
    ndig_r  <= ndig_nxt;
    pos_r   <= pos_nxt;
    char_r  <= char_nxt;
    last_r  <= last_nxt;
    err_r   <= err_nxt;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = char_r;
  assign out_last      = last_r;
  assign out_error     = err_r;

endmodule

// ===== tb/integer_to_radix_digits_unit_test.sv =====
// self-checking testbench for the integer to radix digits unit
`timescale 1ns / 100ps

module integer_to_radix_digits_unit_test;
  import itrd_pkg::*;

  localparam int MAX_TEXT      = 64;    // longest text the unit emits
  localparam int QUIET_LIMIT   = 2000;  // cycles with no item moved on either side
  localparam int SETTLE_CYCLES = 140;   // time to watch for stray items after the text drains
  localparam int PRINT_LIMIT   = 100;

  localparam logic [63:0] MOST_NEGATIVE = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POSITIVE = 64'h7fff_ffff_ffff_ffff;

  // one character of converted text
  typedef struct packed {
    logic [6:0] character;
    logic       last;
    logic       error;
  } char_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic signed [63:0] in_value = '0;
  logic        [5:0]  in_radix = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic        [6:0]  out_character;
  logic              out_last;
  logic              out_error;

  char_result_t expected_chars[$];
  int           mismatch_count = 0;
  int           chars_checked = 0;
  int           quiet_cycles = 0;
  int           in_idle_pct = 0;
  int           out_stall_pct = 0;

  integer_to_radix_digits_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .in_radix     (in_radix),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_character(out_character),
    .out_last     (out_last),
    .out_error    (out_error)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // random receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // watchdog on cycles where no item moves
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // expected text of one number, most significant character first
  function automatic void predict_text(input logic [63:0] value, input logic [5:0] radix);
    logic [63:0]  magnitude;
    logic [63:0]  base;
    logic [5:0]   digit;
    logic [6:0]   text[$];
    char_result_t res;
    if (radix < MIN_RADIX) begin
      res = '{character: CHAR_NONE, last: 1'b1, error: 1'b1};
      expected_chars.push_back(res);
      return;
    end
    magnitude = value[63] ? (~value + 64'd1) : value;
    base = {58'd0, radix};
    do begin
      digit = 6'(magnitude % base);
      text.push_front((digit > DEC_MAX_DIGIT) ? CHAR_ALPHA_BASE + {1'b0, digit}
                                              : CHAR_ZERO + {1'b0, digit});
      magnitude = magnitude / base;
    end while (magnitude != 0);
    // sign only shown in decimal
    if (value[63] && radix == DEC_RADIX) text.push_front(CHAR_MINUS);
    // overlong text keeps its tail
    while (text.size() > MAX_TEXT) void'(text.pop_front());
    for (int i = 0; i < text.size(); i++) begin
      res = '{character: text[i], last: (i == text.size() - 1), error: 1'b0};
      expected_chars.push_back(res);
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [6:0] want,
                                 input logic [6:0] got);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t: character %0d, %s mismatch: expected %0h, got %0h",
               $time, chars_checked, field, want, got);
    mismatch_count++;
  endtask

  // compare each accepted character with the oldest expectation
  always @(posedge clk) begin
    char_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected item", '0, out_character);
      end else begin
        want = expected_chars.pop_front();
        if (out_character !== want.character)
          report_mismatch("character", want.character, out_character);
        if (out_last !== want.last)
          report_mismatch("last", {6'd0, want.last}, {6'd0, out_last});
        if (out_error !== want.error)
          report_mismatch("error", {6'd0, want.error}, {6'd0, out_error});
      end
      chars_checked++;
    end
  end

  // send one number and record its expected text on acceptance
  task automatic send_item(input logic [63:0] value, input logic [5:0] radix);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    in_radix <= radix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_text(value, radix);
  endtask

  // hold off the sender until all text has come back
  task automatic drain_text();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_chars.size() != 0);
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    in_idle_pct = sender_pct;
    out_stall_pct = receiver_pct;
  endtask

  // zero, one, minus one and the range ends in several bases
  task automatic test_special_values();
    send_item(64'd0, DEC_RADIX);
    send_item(64'd0, 6'd2);
    send_item(64'd0, 6'd63);
    send_item(64'd1, 6'd2);
    send_item(-64'sd1, DEC_RADIX);
    send_item(-64'sd1, 6'd16);
    send_item(MOST_NEGATIVE, DEC_RADIX);
    send_item(MOST_NEGATIVE, 6'd2);
    send_item(MOST_NEGATIVE, 6'd16);
    send_item(MOST_NEGATIVE, 6'd63);
    send_item(MOST_POSITIVE, 6'd2);
    send_item(MOST_POSITIVE, DEC_RADIX);
    send_item(MOST_POSITIVE, 6'd36);
    send_item(-64'sd12345, DEC_RADIX);
    send_item(-64'sd255, 6'd16);
  endtask

  // radix below two gives a single error item
  task automatic test_radix_errors();
    send_item(64'd0, 6'd0);
    send_item(MOST_NEGATIVE, 6'd1);
    send_item(MOST_POSITIVE, 6'd0);
    send_item(-64'sd1, 6'd1);
  endtask

  // digit values past nine, up to the largest radix
  task automatic test_letter_digits();
    send_item(64'd10, 6'd11);
    send_item(64'd35, 6'd36);
    send_item(64'd62, 6'd63);
    send_item(64'd63, 6'd63);
    send_item(64'd3968, 6'd63);
  endtask

  // random numbers of mixed shape against random bases
  task automatic test_random_values(input int count);
    logic [63:0] value;
    logic [63:0] power;
    logic [5:0]  radix;
    int          pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 8) radix = 6'($urandom_range(1));
      else if (pick < 35) radix = DEC_RADIX;
      else radix = 6'($urandom_range(63, 2));
      case ($urandom_range(5))
        0: value = {$urandom, $urandom};
        1: value = 64'($urandom_range(1000));
        2: value = -64'($urandom_range(100000, 1));
        3: begin
          value = {$urandom, $urandom} >> $urandom_range(63);
          if ($urandom_range(1)) value = -value;
        end
        4: begin
          // around a power of the base, where the digit count changes
          power = 64'd1;
          repeat ($urandom_range(20, 1)) power = power * {58'd0, (radix < 2) ? 6'd2 : radix};
          value = power + 64'($urandom_range(2)) - 64'd1;
          if ($urandom_range(1)) value = -value;
        end
        default: begin
          case ($urandom_range(3))
            0: value = MOST_NEGATIVE;
            1: value = MOST_POSITIVE;
            2: value = MOST_NEGATIVE + 64'd1;
            default: value = 64'd0;
          endcase
        end
      endcase
      send_item(value, radix);
    end
  endtask

  // test sequence
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    set_idling(7, 62);
    test_special_values();
    test_radix_errors();
    test_letter_digits();
    test_random_values(80);
    drain_text();

    set_idling(62, 7);
    test_random_values(80);
    drain_text();

    set_idling(0, 0);
    test_random_values(80);

    // wait for the remaining text, then watch for stray items
    drain_text();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
